// ===== rtl/gcpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpa_pkg
// shared types and constants of the chunk pool allocator
// ----------------------------------------------------------------------------
package gcpa_pkg;

    localparam int POOL_BLOCKS = 16;
    localparam int CHUNKS_MAX = 32;
    localparam int POOL_DEPTH = POOL_BLOCKS * CHUNKS_MAX;

    localparam int HANDLE_W = 9;
    localparam int CHUNK_W  = 5;
    localparam int BLOCK_W  = 4;
    localparam int LINK_W   = HANDLE_W + 1;
    localparam int OFFSET_W = 17;

    localparam int CPB_W   = 6;
    localparam int MAXB_W  = 5;
    localparam int BYTES_W = 13;
    localparam int CFG_W   = BYTES_W;
    localparam int IDX_W   = 2;

    localparam logic [CPB_W-1:0]   DEFAULT_CHUNKS  = 6'd32;
    localparam logic [MAXB_W-1:0]  DEFAULT_BLOCKS  = 5'd1;
    localparam logic [MAXB_W-1:0]  LIMIT_BLOCKS    = 5'd16;
    localparam logic [BYTES_W-1:0] MIN_CHUNK_BYTES = 13'd8;
    localparam logic [BYTES_W-1:0] MAX_CHUNK_BYTES = 13'd4096;

    localparam logic [IDX_W-1:0] REG_CHUNKS_PER_BLOCK = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_BLOCKS       = 2'd1;
    localparam logic [IDX_W-1:0] REG_CHUNK_BYTES      = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [CPB_W-1:0]   chunks;
        logic [MAXB_W-1:0]  blocks;
        logic [BYTES_W-1:0] bytes;
    } cfg_t;

    typedef struct packed {
        logic                granted;
        logic [HANDLE_W-1:0] handle;
        logic [OFFSET_W-1:0] byte_offset;
        logic                grew;
    } result_t;

endpackage

// ===== rtl/gcpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpa_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module gcpa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gcpa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpa_ctrl
// free list head, bump pointer, request sequencing and result register
// ----------------------------------------------------------------------------
module gcpa_ctrl
    import gcpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                req_op,
    input  logic [HANDLE_W-1:0] req_handle,
    output logic                res_valid,
    input  logic                res_ready,
    output result_t             res,
    output logic                mem_we,
    output logic [HANDLE_W-1:0] mem_waddr,
    output logic [LINK_W-1:0]   mem_wdata,
    output logic [HANDLE_W-1:0] mem_raddr,
    input  logic [LINK_W-1:0]   mem_rdata
);

    typedef enum logic {ST_IDLE, ST_POP} state_t;

    state_t               state_reg;
    logic [LINK_W-1:0]    head_reg;
    logic [MAXB_W-1:0]    blocks_reg;
    logic [CPB_W-1:0]     fresh_reg;
    logic [HANDLE_W-1:0]  pop_handle_reg;
    logic                 res_valid_reg;
    result_t              res_reg;

    logic                 accept;
    logic                 res_load;
    logic                 can_fresh;
    logic                 can_grow;
    logic [CHUNK_W-1:0]   mul_chunk;
    logic [OFFSET_W:0]    mul_full;
    logic [OFFSET_W-1:0]  offset;
    logic [BLOCK_W-1:0]   fresh_block;
    result_t              res_next;

    assign req_ready = (state_reg == ST_IDLE) && (!res_valid_reg || res_ready);
    assign accept    = req_valid && req_ready;

    // every request except a pop loads the result register when taken
    assign res_load  = (state_reg == ST_POP)
                       || (accept && !((req_op == OP_ALLOC) && head_reg[HANDLE_W]));

    assign mem_we    = accept && (req_op == OP_FREE);
    assign mem_waddr = req_handle;
    assign mem_wdata = head_reg;
    assign mem_raddr = head_reg[HANDLE_W-1:0];

    assign can_fresh   = (blocks_reg != '0) && (fresh_reg < cfg.chunks);
    assign can_grow    = blocks_reg < cfg.blocks;
    assign fresh_block = BLOCK_W'(blocks_reg - 5'd1);

    always_comb
    begin
        mul_chunk = (state_reg == ST_POP) ? pop_handle_reg[CHUNK_W-1:0]
                                          : fresh_reg[CHUNK_W-1:0];
        mul_full  = (OFFSET_W+1)'(mul_chunk) * (OFFSET_W+1)'(cfg.bytes);
        offset    = mul_full[OFFSET_W-1:0];
    end

    always_comb
    begin
        res_next = '0;
        if (state_reg == ST_POP)
        begin
            res_next.granted     = 1'b1;
            res_next.handle      = pop_handle_reg;
            res_next.byte_offset = offset;
        end
        else if (req_op == OP_FREE)
        begin
            res_next.granted = 1'b1;
            res_next.handle  = req_handle;
        end
        else if (can_fresh)
        begin
            res_next.granted     = 1'b1;
            res_next.handle      = {fresh_block, fresh_reg[CHUNK_W-1:0]};
            res_next.byte_offset = offset;
        end
        else if (can_grow)
        begin
            res_next.granted = 1'b1;
            res_next.handle  = {blocks_reg[BLOCK_W-1:0], {CHUNK_W{1'b0}}};
            res_next.grew    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            blocks_reg     <= '0;
            fresh_reg      <= '0;
            pop_handle_reg <= '0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (req_op == OP_FREE)
                        begin
                            head_reg <= {1'b1, req_handle};
                            res_reg  <= res_next;
                        end
                        else if (head_reg[HANDLE_W])
                        begin
                            // pop waits in ST_POP for the registered link read
                            pop_handle_reg <= head_reg[HANDLE_W-1:0];
                            state_reg      <= ST_POP;
                        end
                        else
                        begin
                            res_reg <= res_next;
                            if (can_fresh)
                            begin
                                fresh_reg <= fresh_reg + 6'd1;
                            end
                            else if (can_grow)
                            begin
                                blocks_reg <= blocks_reg + 5'd1;
                                fresh_reg  <= 6'd1;
                            end
                        end
                    end
                end
                ST_POP:
                begin
                    head_reg  <= mem_rdata;
                    res_reg   <= res_next;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/growable_chunk_pool_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// growable_chunk_pool_allocator_unit
// fixed-size chunk allocator with a lifo free list and block growth
// ----------------------------------------------------------------------------
// requests enter on the s_ stream: s_tuser is the op (0 alloc, 1 free),
// s_tdata carries the handle to free. every request gives one result on the
// m_ stream: m_tuser holds granted and grew, m_tdata the handle and the
// chunk's byte offset within its block.
// a free, a fresh-chunk alloc, a grow or an exhausted alloc loads the result
// register when taken; an alloc that pops the free list first passes the pop
// state for the registered read of the link ram that yields the next list
// head, and no new request is taken in that state. the result appears in the
// cycle after the request is taken, or after the pop state for a pop; all but
// pops run at one request per cycle while the result side keeps up.
// a held result stalls the input side: a new request is taken only in the
// cycle in which the result register empties or is already empty.
// reset empties the free list, closes all blocks and sets chunks per block
// to 32, max blocks to 1, chunk bytes to 8. the link ram needs no clearing.
// configuration writes on cfg_we apply at once; write only while idle.
// ----------------------------------------------------------------------------
module growable_chunk_pool_allocator_unit
    import gcpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // free_handle
    input  logic             s_tuser,   // op
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // handle, byte_offset
    output logic [1:0]       m_tuser    // granted, grew
);

    logic [CPB_W-1:0]    cpb_reg;
    logic [MAXB_W-1:0]   maxb_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    cfg_t                cfg;
    result_t             res;

    logic                mem_we;
    logic [HANDLE_W-1:0] mem_waddr;
    logic [LINK_W-1:0]   mem_wdata;
    logic [HANDLE_W-1:0] mem_raddr;
    logic [LINK_W-1:0]   mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpb_reg   <= DEFAULT_CHUNKS;
            maxb_reg  <= DEFAULT_BLOCKS;
            bytes_reg <= MIN_CHUNK_BYTES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHUNKS_PER_BLOCK: cpb_reg   <= cfg_data[CPB_W-1:0];
                REG_MAX_BLOCKS:       maxb_reg  <= cfg_data[MAXB_W-1:0];
                REG_CHUNK_BYTES:      bytes_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // clamp register values to their usable ranges
    always_comb
    begin
        cfg.chunks = ((cpb_reg == '0) || (cpb_reg > DEFAULT_CHUNKS)) ? DEFAULT_CHUNKS
                                                                     : cpb_reg;
        if (maxb_reg == '0)
        begin
            cfg.blocks = DEFAULT_BLOCKS;
        end
        else if (maxb_reg > LIMIT_BLOCKS)
        begin
            cfg.blocks = LIMIT_BLOCKS;
        end
        else
        begin
            cfg.blocks = maxb_reg;
        end
        if (bytes_reg < MIN_CHUNK_BYTES)
        begin
            cfg.bytes = MIN_CHUNK_BYTES;
        end
        else if (bytes_reg > MAX_CHUNK_BYTES)
        begin
            cfg.bytes = MAX_CHUNK_BYTES;
        end
        else
        begin
            cfg.bytes = bytes_reg;
        end
    end

    gcpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    gcpa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_op     (s_tuser),
        .req_handle (s_tdata[HANDLE_W-1:0]),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    assign m_tdata = {6'd0, res.byte_offset, res.handle};
    assign m_tuser = {res.grew, res.granted};

    // a held result blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("request taken while result held");

    // a free is answered in the next cycle
    a_free_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == OP_FREE) |=> m_tvalid)
        else $error("free result missing");

    // a grow hands out chunk zero of the new block
    a_grow_chunk0: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && m_tdata[4:0] == 5'd0
                                      && m_tdata[25:9] == 17'd0))
        else $error("grow result not at chunk zero");

    // an exhausted alloc carries all zero fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0 && !m_tuser[1]))
        else $error("failed result not zero");

endmodule

// ===== test/tb_growable_chunk_pool_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_growable_chunk_pool_allocator_unit
// self-checking bench for the chunk pool allocator: a local copy of the free
// list, block count and fresh-chunk pointer predicts every grant; directed
// cases cover register limits, exhaustion and growth, then random phases mix
// allocs with frees of held chunks under bursty input and stalling output
// ----------------------------------------------------------------------------
module tb_growable_chunk_pool_allocator_unit;
    import gcpa_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 150;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata = '0;   // free_handle
    logic             s_tuser = 1'b0; // op
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [31:0]      m_tdata;        // handle, byte_offset
    logic [1:0]       m_tuser;        // granted, grew

    growable_chunk_pool_allocator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // allocator state as the bench sees it
    logic [LINK_W-1:0]   free_links [POOL_DEPTH];
    logic [LINK_W-1:0]   free_head = '0;
    logic [MAXB_W-1:0]   blocks_open = '0;
    logic [CPB_W-1:0]    next_fresh = '0;
    cfg_t                pool_cfg = '{DEFAULT_CHUNKS, DEFAULT_BLOCKS, MIN_CHUNK_BYTES};

    result_t             pending_grants [$];
    logic [HANDLE_W-1:0] held_chunks [$];
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  burst_left = 0;
    bit                  sender_gaps = 1'b1;

    logic                hold_toggle = 1'b0;
    logic                hold_seen = 1'b0;
    int                  hold_left = 0;
    int                  ready_mode = 0;
    int                  mode_left = 0;
    logic [1:0]          ready_phase = '0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_growable_chunk_pool_allocator_unit: done, errors");
            $finish;
        end
    end

    function automatic result_t predict_grant(input logic op, input logic [HANDLE_W-1:0] fh);
        result_t             res;
        int                  chunks;
        int                  blocks;
        int                  stride;
        logic [HANDLE_W-1:0] h;
        res = '0;
        chunks = (pool_cfg.chunks == 0) ? int'(DEFAULT_CHUNKS) :
                 (pool_cfg.chunks > CHUNKS_MAX) ? CHUNKS_MAX : int'(pool_cfg.chunks);
        blocks = (pool_cfg.blocks == 0) ? int'(DEFAULT_BLOCKS) :
                 (pool_cfg.blocks > LIMIT_BLOCKS) ? int'(LIMIT_BLOCKS) : int'(pool_cfg.blocks);
        stride = (pool_cfg.bytes < MIN_CHUNK_BYTES) ? int'(MIN_CHUNK_BYTES) :
                 (pool_cfg.bytes > MAX_CHUNK_BYTES) ? int'(MAX_CHUNK_BYTES) : int'(pool_cfg.bytes);
        if (op == OP_FREE)
        begin
            free_links[fh] = free_head;
            free_head = {1'b1, fh};
            res.granted = 1'b1;
            res.handle = fh;
        end
        else if (free_head[HANDLE_W])
        begin
            h = free_head[HANDLE_W-1:0];
            free_head = free_links[h];
            res.granted = 1'b1;
            res.handle = h;
            res.byte_offset = OFFSET_W'(int'(h[CHUNK_W-1:0]) * stride);
        end
        else if (blocks_open != 0 && int'(next_fresh) < chunks)
        begin
            res.granted = 1'b1;
            res.handle = HANDLE_W'((int'(blocks_open) - 1) * CHUNKS_MAX + int'(next_fresh));
            res.byte_offset = OFFSET_W'(int'(next_fresh) * stride);
            next_fresh = next_fresh + 6'd1;
        end
        else if (int'(blocks_open) < blocks)
        begin
            res.granted = 1'b1;
            res.handle = HANDLE_W'(int'(blocks_open) * CHUNKS_MAX);
            res.grew = 1'b1;
            blocks_open = blocks_open + 5'd1;
            next_fresh = CPB_W'(1);
        end
        return res;
    endfunction

    // result check and output-side stall pattern
    always @(posedge clk)
    begin
        result_t want;
        if (m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (pending_grants.size() == 0)
            begin
                $error("unexpected result handle %0d", m_tdata[HANDLE_W-1:0]);
                error_count++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (m_tuser[0] !== want.granted)
                begin
                    $error("granted: expected %0d, got %0d", want.granted, m_tuser[0]);
                    error_count++;
                end
                if (m_tdata[HANDLE_W-1:0] !== want.handle)
                begin
                    $error("handle: expected %0d, got %0d", want.handle,
                           m_tdata[HANDLE_W-1:0]);
                    error_count++;
                end
                if (m_tdata[HANDLE_W +: OFFSET_W] !== want.byte_offset)
                begin
                    $error("byte_offset: expected %0d, got %0d", want.byte_offset,
                           m_tdata[HANDLE_W +: OFFSET_W]);
                    error_count++;
                end
                if (m_tuser[1] !== want.grew)
                begin
                    $error("grew: expected %0d, got %0d", want.grew, m_tuser[1]);
                    error_count++;
                end
            end
        end

        ready_phase <= ready_phase + 2'd1;
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 80);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 9) < 7);
                2:       m_tready <= ($urandom_range(0, 9) < 3);
                default: m_tready <= (ready_phase == 2'd0);
            endcase
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_CHUNKS_PER_BLOCK: pool_cfg.chunks = value[CPB_W-1:0];
            REG_MAX_BLOCKS:       pool_cfg.blocks = value[MAXB_W-1:0];
            REG_CHUNK_BYTES:      pool_cfg.bytes = value[BYTES_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(input logic op, input logic [HANDLE_W-1:0] fh);
        result_t want;
        int      gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = sender_gaps ? $urandom_range(1, 5) : 0;
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        want = predict_grant(op, fh);
        pending_grants.push_back(want);
        if (op == OP_ALLOC && want.granted)
            held_chunks.push_back(want.handle);
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, fh};
        s_tuser <= op;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // reset registers: 32 chunks, one block, 8-byte stride
    task automatic test_first_grants();
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 9'd1);
        send_request(OP_FREE, 9'd511);
        send_request(OP_FREE, 9'd0);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        wait_for_idle();
        held_chunks.delete();
    endtask

    // out-of-range register values clamp
    task automatic test_register_limits();
        write_reg(REG_CHUNK_BYTES, 13'd8191);
        send_request(OP_FREE, 9'd31);
        send_request(OP_ALLOC, '0);
        wait_for_idle();
        write_reg(REG_CHUNK_BYTES, 13'd7);
        send_request(OP_ALLOC, '0);
        wait_for_idle();
        write_reg(REG_CHUNKS_PER_BLOCK, 13'd63);
        send_request(OP_ALLOC, '0);
        wait_for_idle();
        write_reg(REG_CHUNKS_PER_BLOCK, 13'd0);
        write_reg(REG_CHUNK_BYTES, 13'd0);
        send_request(OP_ALLOC, '0);
        wait_for_idle();
    endtask

    // shrinking chunk count closes the block, then grow and run out
    task automatic test_exhaustion_growth();
        write_reg(REG_CHUNKS_PER_BLOCK, 13'd1);
        write_reg(REG_MAX_BLOCKS, 13'd0);
        send_request(OP_ALLOC, '0);
        wait_for_idle();
        write_reg(REG_MAX_BLOCKS, 13'd31);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        wait_for_idle();
        write_reg(REG_MAX_BLOCKS, 13'd2);
        send_request(OP_ALLOC, '0);
        wait_for_idle();
    endtask

    // output held off while requests keep coming
    task automatic test_output_hold();
        int idx;
        write_reg(REG_CHUNKS_PER_BLOCK, 13'd4);
        write_reg(REG_MAX_BLOCKS, 13'd6);
        write_reg(REG_CHUNK_BYTES, 13'd100);
        sender_gaps = 1'b0;
        hold_toggle <= ~hold_toggle;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 3 == 2 && held_chunks.size() != 0)
            begin
                idx = $urandom_range(0, held_chunks.size() - 1);
                send_request(OP_FREE, held_chunks[idx]);
                held_chunks.delete(idx);
            end
            else
            begin
                send_request(OP_ALLOC, '0);
            end
        end
        wait_for_idle();
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_mix();
        int                  chunk_pick [8] = '{1, 0, 3, 63, -1, 32, 2, -1};
        int                  block_pick [8] = '{2, 0, 5, 3, 9, 31, 12, 16};
        int                  byte_pick [8] = '{8191, 0, 4096, 8, -1, 7, 4097, -1};
        int                  alloc_pct;
        int                  idx;
        logic [HANDLE_W-1:0] fh;
        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_CHUNKS_PER_BLOCK,
                      chunk_pick[p] < 0 ? CFG_W'($urandom_range(0, 63))
                                        : CFG_W'(chunk_pick[p]));
            write_reg(REG_MAX_BLOCKS, CFG_W'(block_pick[p]));
            write_reg(REG_CHUNK_BYTES,
                      byte_pick[p] < 0 ? CFG_W'($urandom_range(0, 8191))
                                       : CFG_W'(byte_pick[p]));
            alloc_pct = $urandom_range(35, 75);
            sender_gaps = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 170; i++)
            begin
                if ($urandom_range(0, 99) < alloc_pct)
                begin
                    send_request(OP_ALLOC, '0);
                end
                else if (held_chunks.size() != 0 && $urandom_range(0, 99) < 85)
                begin
                    idx = $urandom_range(0, held_chunks.size() - 1);
                    fh = held_chunks[idx];
                    held_chunks.delete(idx);
                    send_request(OP_FREE, fh);
                end
                else
                begin
                    // stray or repeated free
                    send_request(OP_FREE, HANDLE_W'($urandom_range(0, POOL_DEPTH - 1)));
                end
            end
            wait_for_idle();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_grants();
        test_register_limits();
        test_exhaustion_growth();
        test_output_hold();
        test_random_mix();
        wait_for_idle();
        if (error_count == 0 && pending_grants.size() == 0)
            $display("tb_growable_chunk_pool_allocator_unit: done, clean");
        else
            $display("tb_growable_chunk_pool_allocator_unit: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gcpa_pkg.sv
rtl/gcpa_ram.sv
rtl/gcpa_ctrl.sv
rtl/growable_chunk_pool_allocator_unit.sv
test/tb_growable_chunk_pool_allocator_unit.sv
